[hdl/assert_macros.svh]
// Assertion macros for the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/dpvc_pkg.sv]
// Types, codes and constants of the drain pump valve controller.
package dpvc_pkg;

  localparam int unsigned TimerW     = 16;
  localparam int unsigned CurrentW   = 10;
  localparam int unsigned DryW       = 7;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [TimerW-1:0]   RunLimitReset   = 16'd3000;
  localparam logic [TimerW-1:0]   FinishTimeReset = 16'd600;
  localparam logic [TimerW-1:0]   ValveOpenReset  = 16'd400;
  localparam logic [CurrentW-1:0] FeedbackReset   = 10'd100;
  localparam logic [TimerW:0]     FeedbackDelay   = 17'd30;
  localparam logic [DryW-1:0]     DryLimit        = 7'd100;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_RUN_LIMIT       = 2'd0,
    CFG_FINISH_TIME     = 2'd1,
    CFG_VALVE_OPEN_TIME = 2'd2,
    CFG_FEEDBACK_THR    = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    TONE_NONE    = 2'd0,
    TONE_WARNING = 2'd1,
    TONE_ON      = 2'd2,
    TONE_OFF     = 2'd3
  } tone_t;

  typedef enum logic [1:0] {
    LEVEL_EMPTY  = 2'd0,
    LEVEL_LOW    = 2'd1,
    LEVEL_HIGH   = 2'd2,
    LEVEL_SENSOR = 2'd3
  } level_t;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_KEY  = 1'b1
  } kind_t;

  typedef struct packed {
    logic                kind;
    logic                filter_ok;
    logic                all_lock;
    logic                memento_active;
    logic                pump_error;
    logic                leak_error;
    logic                auto_drain_busy;
    logic                water_out;
    logic [1:0]          drain_level;
    logic [CurrentW-1:0] pump_current;
  } in_item_t;

  typedef struct packed {
    logic       pump_on;
    logic       valve_on;
    logic       running;
    logic [1:0] tone;
  } out_item_t;

endpackage

[hdl/dpvc_if.sv]
// Valid/ready channel interfaces: input beats, result beats and register writes.
interface dpvc_in_if;
  import dpvc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dpvc_out_if;
  import dpvc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dpvc_cfg_if;
  import dpvc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CfgIndexW-1:0] index;
  logic [CfgDataW-1:0]  wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

[hdl/drain_pump_valve_controller_unit.sv]
// Manual drain controller: key and tick beats in, drive and tone beats out.
//
// Channels: in_ch carries one beat per key press or periodic tick, with the
// interlock flags, the tank level code and a pump current sample. out_ch
// returns exactly one beat per input beat: pump and valve drives, the run
// flag and the tone, all as they stand after that beat. cfg_ch writes one
// of four registers (run limit, finish time, valve open time, feedback
// threshold); it is always ready and is meant to be used while idle.
// Latency: the result beat is valid in the cycle after its input beat.
// Throughput: one beat per cycle. The whole update is a short compare and
// counter step from the state registers into the result register, so a
// new beat is taken every cycle the result register is empty or drained.
// Reset (rst_n low, synchronous) stops the drain, zeroes all timers and
// drives, empties the result register and reloads register defaults.
// A stalled receiver holds the result beat; in_ch.ready drops only while
// a result waits and out_ch.ready is low.
module drain_pump_valve_controller_unit (
  input logic             clk,
  input logic             rst_n,
  dpvc_cfg_if.sink        cfg_ch,
  dpvc_in_if.sink         in_ch,
  dpvc_out_if.source      out_ch
);
  import dpvc_pkg::*;

  // Configuration registers
  logic [TimerW-1:0]   run_limit_r;
  logic [TimerW-1:0]   finish_time_r;
  logic [TimerW-1:0]   valve_open_time_r;
  logic [CurrentW-1:0] feedback_thr_r;

  // Drain state
  logic              run_flag_r,       run_flag_nxt;
  logic              pump_drive_r,     pump_drive_nxt;
  logic              valve_drive_r,    valve_drive_nxt;
  logic              came_from_high_r, came_from_high_nxt;
  logic [TimerW-1:0] run_timer_r,      run_timer_nxt;
  logic [TimerW-1:0] start_timer_r,    start_timer_nxt;
  logic [TimerW-1:0] empty_timer_r,    empty_timer_nxt;
  logic [DryW-1:0]   dry_count_r,      dry_count_nxt;

  // Result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r,  out_data_nxt;

  logic      in_beat;
  logic      fault;
  logic      no_flow;
  logic [TimerW:0] open_end;
  tone_t     tone;

  function automatic logic [TimerW-1:0] sat_inc(input logic [TimerW-1:0] v);
    sat_inc = (v == {TimerW{1'b1}}) ? v : v + 1'b1;
  endfunction

  assign cfg_ch.ready = 1'b1;

  // Take a beat whenever the result register is free or being drained
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_beat     = in_ch.valid && in_ch.ready;

  assign fault   = !in_ch.data.filter_ok || in_ch.data.pump_error ||
                   in_ch.data.leak_error || in_ch.data.auto_drain_busy;
  assign no_flow  = in_ch.data.pump_current <= feedback_thr_r;
  assign open_end = {1'b0, valve_open_time_r} + FeedbackDelay;

  always_comb begin
    run_flag_nxt       = run_flag_r;
    pump_drive_nxt     = pump_drive_r;
    valve_drive_nxt    = valve_drive_r;
    came_from_high_nxt = came_from_high_r;
    run_timer_nxt      = run_timer_r;
    start_timer_nxt    = start_timer_r;
    empty_timer_nxt    = empty_timer_r;
    dry_count_nxt      = dry_count_r;
    tone               = TONE_NONE;

    if (in_ch.data.kind == KIND_KEY) begin
      // Key press: interlocks first, then toggle; drives follow on the next tick
      if (!in_ch.data.filter_ok || in_ch.data.all_lock) begin
        tone = TONE_WARNING;
      end else if (!in_ch.data.memento_active) begin
        if (!run_flag_r) begin
          if (fault || in_ch.data.water_out) begin
            tone = TONE_WARNING;
          end else begin
            tone         = TONE_ON;
            run_flag_nxt = 1'b1;
          end
        end else begin
          tone         = TONE_OFF;
          run_flag_nxt = 1'b0;
        end
      end
    end else begin
      // Tick: abort on a fault, otherwise advance the level sequence
      if (run_flag_r && fault) begin
        tone         = TONE_WARNING;
        run_flag_nxt = 1'b0;
      end
      if (!run_flag_nxt || (sat_inc(run_timer_r) >= run_limit_r)) begin
        // Stopped or out of time: drop drives and clear all timers
        run_flag_nxt       = 1'b0;
        run_timer_nxt      = '0;
        pump_drive_nxt     = 1'b0;
        valve_drive_nxt    = 1'b0;
        came_from_high_nxt = 1'b0;
        start_timer_nxt    = '0;
        empty_timer_nxt    = '0;
        dry_count_nxt      = '0;
      end else begin
        run_timer_nxt = sat_inc(run_timer_r);
        case (in_ch.data.drain_level)
          LEVEL_EMPTY: begin
            pump_drive_nxt     = 1'b0;
            came_from_high_nxt = 1'b0;
            start_timer_nxt    = '0;
            dry_count_nxt      = '0;
            empty_timer_nxt    = sat_inc(empty_timer_r);
            if (empty_timer_nxt >= finish_time_r) begin
              // Finished: force the run timer to the limit so the next tick stops
              empty_timer_nxt = '0;
              run_timer_nxt   = run_limit_r;
            end
          end
          LEVEL_LOW: begin
            empty_timer_nxt = '0;
            if (!came_from_high_r) begin
              // Delayed pump start after empty, then a feedback check on every tick; no flow restarts the delay
              start_timer_nxt = sat_inc(start_timer_r);
              if (start_timer_nxt >= valve_open_time_r) begin
                pump_drive_nxt = 1'b1;
                if ({1'b0, start_timer_nxt} >= open_end) begin
                  start_timer_nxt = no_flow ? '0 : open_end[TimerW-1:0];
                end
              end else begin
                pump_drive_nxt = 1'b0;
              end
            end else begin
              // Falling from high: count dry samples, stop pump at the cap
              start_timer_nxt = '0;
              if (no_flow) begin
                if (dry_count_r + 1'b1 >= DryLimit) begin
                  dry_count_nxt  = DryLimit;
                  pump_drive_nxt = 1'b0;
                end else begin
                  dry_count_nxt  = dry_count_r + 1'b1;
                  pump_drive_nxt = 1'b1;
                end
              end else begin
                dry_count_nxt  = '0;
                pump_drive_nxt = 1'b1;
              end
            end
          end
          default: begin
            // High level or sensor error: pump on, remember the high extreme
            pump_drive_nxt     = 1'b1;
            came_from_high_nxt = 1'b1;
            dry_count_nxt      = '0;
          end
        endcase
        // Hold the valve open for the whole run
        valve_drive_nxt = 1'b1;
      end
    end

    out_data_nxt.pump_on  = pump_drive_nxt;
    out_data_nxt.valve_on = valve_drive_nxt;
    out_data_nxt.running  = run_flag_nxt;
    out_data_nxt.tone     = tone;

    out_valid_nxt = in_beat || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_limit_r       <= RunLimitReset;
      finish_time_r     <= FinishTimeReset;
      valve_open_time_r <= ValveOpenReset;
      feedback_thr_r    <= FeedbackReset;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_RUN_LIMIT:       run_limit_r       <= cfg_ch.wdata;
        CFG_FINISH_TIME:     finish_time_r     <= cfg_ch.wdata;
        CFG_VALVE_OPEN_TIME: valve_open_time_r <= cfg_ch.wdata;
        CFG_FEEDBACK_THR:    feedback_thr_r    <= cfg_ch.wdata[CurrentW-1:0];
        default:             run_limit_r       <= run_limit_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_flag_r       <= 1'b0;
      pump_drive_r     <= 1'b0;
      valve_drive_r    <= 1'b0;
      came_from_high_r <= 1'b0;
      run_timer_r      <= '0;
      start_timer_r    <= '0;
      empty_timer_r    <= '0;
      dry_count_r      <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_beat) begin
        run_flag_r       <= run_flag_nxt;
        pump_drive_r     <= pump_drive_nxt;
        valve_drive_r    <= valve_drive_nxt;
        came_from_high_r <= came_from_high_nxt;
        run_timer_r      <= run_timer_nxt;
        start_timer_r    <= start_timer_nxt;
        empty_timer_r    <= empty_timer_nxt;
        dry_count_r      <= dry_count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_dry_count_capped, dry_count_r <= DryLimit)
  `ASSERT_NEXT(a_beat_gives_result, in_beat, out_valid_r)
  `ASSERT_NEXT(a_valve_open_while_running,
               in_beat && (in_ch.data.kind == KIND_TICK) && run_flag_nxt,
               out_data_r.valve_on && out_data_r.running)

endmodule
